FILE: src/assert_macros.svh
// Assertion macros shared by the field splitter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: src/csfs_pkg.sv
// Shared types and constants for the CSV field splitter.
// Depends on nothing; used by all modules of the block.
package csfs_pkg;

   // Field limits
   localparam int MAX_FIELDS = 32;
   localparam int CNT_W      = 6;
   localparam int IDX_W      = 5;
   localparam int SEP_NUM    = 4;

   localparam logic [7:0] QUOTE_BYTE = 8'h22;
   localparam logic [7:0] SEP_RESET  = 8'd44;
   localparam logic [2:0] COUNT_RESET = 3'd1;

   // Register indexes on the CSR port
   localparam logic [2:0] REG_SEP0  = 3'd0;
   localparam logic [2:0] REG_SEP1  = 3'd1;
   localparam logic [2:0] REG_SEP2  = 3'd2;
   localparam logic [2:0] REG_SEP3  = 3'd3;
   localparam logic [2:0] REG_COUNT = 3'd4;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_PLAIN,
      MODE_QUOTED,
      MODE_QUOTE_SEEN,
      MODE_TAIL
   } mode_type;

   typedef struct packed {
      logic [SEP_NUM-1:0][7:0] sep_char;
      logic [2:0]              sep_count;
   } cfg_type;

   typedef struct packed {
      logic             has_result;
      logic [7:0]       data_byte;
      logic             data_valid;
      logic             field_end;
      logic             line_end;
      logic [IDX_W-1:0] field_index;
      logic             field_overflow;
   } result_type;

endpackage

FILE: src/csfs_csr.sv
// Configuration registers of the CSV field splitter (separator set, count).
// Depends on csfs_pkg.
module csfs_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output csfs_pkg::cfg_type cfg
);

   logic [csfs_pkg::SEP_NUM-1:0][7:0] sep_ff;
   logic [2:0]                        count_ff;
   logic [2:0]                        reg_idx;
   logic                              wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Write registers on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff   <= {csfs_pkg::SEP_NUM{csfs_pkg::SEP_RESET}};
         count_ff <= csfs_pkg::COUNT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            csfs_pkg::REG_SEP0:  sep_ff[0] <= csr_pwdata[7:0];
            csfs_pkg::REG_SEP1:  sep_ff[1] <= csr_pwdata[7:0];
            csfs_pkg::REG_SEP2:  sep_ff[2] <= csr_pwdata[7:0];
            csfs_pkg::REG_SEP3:  sep_ff[3] <= csr_pwdata[7:0];
            csfs_pkg::REG_COUNT: count_ff  <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         csfs_pkg::REG_SEP0:  csr_prdata = {24'd0, sep_ff[0]};
         csfs_pkg::REG_SEP1:  csr_prdata = {24'd0, sep_ff[1]};
         csfs_pkg::REG_SEP2:  csr_prdata = {24'd0, sep_ff[2]};
         csfs_pkg::REG_SEP3:  csr_prdata = {24'd0, sep_ff[3]};
         csfs_pkg::REG_COUNT: csr_prdata = {29'd0, count_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign cfg.sep_char  = sep_ff;
   assign cfg.sep_count = count_ff;

endmodule

FILE: src/csfs_parse.sv
// Parse state machine: classifies one byte and keeps mode, field count and
// overflow across the line. Depends on csfs_pkg.
module csfs_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  csfs_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  logic                 advance,
   input  logic [7:0]           char_byte,
   input  logic                 end_of_line,
   output csfs_pkg::result_type result
);

   csfs_pkg::mode_type          mode_ff, mode_in;
   logic [csfs_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        over_ff, over_in;

   logic [2:0]                  eff_count;
   logic [csfs_pkg::SEP_NUM-1:0] sep_hit;
   logic                        is_sep;
   logic                        is_quote;
   logic                        data_valid;
   logic                        fend;
   logic                        step;
   logic                        at_limit;

   // Clamp the active separator count to one..four
   always_comb begin
      if (cfg.sep_count == 3'd0) begin
         eff_count = 3'd1;
      end else if (cfg.sep_count > 3'd4) begin
         eff_count = 3'd4;
      end else begin
         eff_count = cfg.sep_count;
      end
   end

   // Match against each active separator
   always_comb begin
      for (int i = 0; i < csfs_pkg::SEP_NUM; i++) begin
         sep_hit[i] = (cfg.sep_char[i] == char_byte) && (3'(i) < eff_count);
      end
   end

   assign is_sep   = |sep_hit;
   assign is_quote = (char_byte == csfs_pkg::QUOTE_BYTE);
   assign step     = item_valid & advance;
   assign at_limit = (count_ff == csfs_pkg::CNT_W'(csfs_pkg::MAX_FIELDS - 1));

   // Output decode: data or field end for this byte
   always_comb begin
      data_valid = 1'b0;
      fend       = 1'b0;
      case (mode_ff)
         csfs_pkg::MODE_PLAIN, csfs_pkg::MODE_TAIL: begin
            if (is_sep) fend = 1'b1;
            else        data_valid = 1'b1;
         end
         csfs_pkg::MODE_QUOTED: begin
            if (!is_quote) data_valid = 1'b1;
         end
         csfs_pkg::MODE_QUOTE_SEEN: begin
            if (is_quote)    data_valid = 1'b1;
            else if (is_sep) fend = 1'b1;
            else             data_valid = 1'b1;
         end
         default: begin
            if (is_quote)    data_valid = 1'b0;
            else if (is_sep) fend = 1'b1;
            else             data_valid = 1'b1;
         end
      endcase
      if (end_of_line) fend = 1'b1;
   end

   // Next state: mode, field counter, overflow
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      over_in  = over_ff;
      case (mode_ff)
         csfs_pkg::MODE_PLAIN, csfs_pkg::MODE_TAIL: ;
         csfs_pkg::MODE_QUOTED: begin
            if (is_quote) mode_in = csfs_pkg::MODE_QUOTE_SEEN;
         end
         csfs_pkg::MODE_QUOTE_SEEN: begin
            if (is_quote)     mode_in = csfs_pkg::MODE_QUOTED;
            else if (!is_sep) mode_in = csfs_pkg::MODE_TAIL;
         end
         default: begin
            if (is_quote)     mode_in = csfs_pkg::MODE_QUOTED;
            else if (!is_sep) mode_in = csfs_pkg::MODE_PLAIN;
         end
      endcase
      if (fend) begin
         mode_in = csfs_pkg::MODE_START;
         if (at_limit) over_in  = 1'b1;
         else          count_in = count_ff + 1'b1;
      end
      if (end_of_line) begin
         mode_in  = csfs_pkg::MODE_START;
         count_in = '0;
         over_in  = 1'b0;
      end
   end

   // Advance state when the item leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= csfs_pkg::MODE_START;
         count_ff <= '0;
         over_ff  <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         over_ff  <= over_in;
      end
   end

   assign result.has_result     = data_valid | fend;
   assign result.data_byte      = data_valid ? char_byte : 8'd0;
   assign result.data_valid     = data_valid;
   assign result.field_end      = fend;
   assign result.line_end       = end_of_line;
   assign result.field_index    = count_ff[csfs_pkg::IDX_W-1:0];
   assign result.field_overflow = over_ff;

endmodule

FILE: src/csv_field_splitter_unit.sv
// CSV field splitter top level: input stage, parser and result register.
// Depends on csfs_pkg, csfs_csr, csfs_parse and assert_macros.svh.

// Splits a line, one byte per item with its last byte flagged, into fields
// at any of up to four separator bytes, honoring double-quoted fields. The
// block takes one byte every cycle unless the result channel stalls. A byte
// is held in the input register, classified by the combinational parse step
// and its result is held in the result register. Bytes that yield nothing
// (opening quotes, closing quotes not at line end) produce no result item.
// Separator registers must be written only while no line is in flight.
`include "assert_macros.svh"

module csv_field_splitter_unit (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_line,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_data_valid,
   output logic        rsp_field_end,
   output logic        rsp_line_end,
   output logic [4:0]  rsp_field_index,
   output logic        rsp_field_overflow,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   csfs_pkg::cfg_type    cfg;
   csfs_pkg::result_type result;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eol_ff;
   logic       advance;

   logic                 out_valid_ff, out_valid_in;
   csfs_pkg::result_type out_ff;

   csfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Input stage moves on when the result register is free or draining
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_char_byte;
         in_eol_ff  <= req_end_of_line;
      end
   end

   csfs_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item_valid  (in_valid_ff),
      .advance     (advance),
      .char_byte   (in_byte_ff),
      .end_of_line (in_eol_ff),
      .result      (result)
   );

   // Result register: drop bytes that yield no item
   assign out_valid_in = in_valid_ff && result.has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && out_valid_in) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data_byte      = out_ff.data_byte;
   assign rsp_data_valid     = out_ff.data_valid;
   assign rsp_field_end      = out_ff.field_end;
   assign rsp_line_end       = out_ff.line_end;
   assign rsp_field_index    = out_ff.field_index;
   assign rsp_field_overflow = out_ff.field_overflow;

   // Checks
   `ASSERT_IMPLIES(a_line_end_ends_field, clock, reset, rsp_valid && rsp_line_end,
      rsp_field_end, "line end without field end")
   `ASSERT_IMPLIES(a_empty_byte_zero, clock, reset, rsp_valid && !rsp_data_valid,
      rsp_data_byte == 8'd0, "data byte set without data")
   `ASSERT_IMPLIES(a_overflow_saturated, clock, reset, rsp_valid && rsp_field_overflow,
      rsp_field_index == 5'(csfs_pkg::MAX_FIELDS - 1), "overflow below last index")
   `ASSERT_ALWAYS(a_result_has_content, clock, reset,
      !rsp_valid || rsp_data_valid || rsp_field_end, "result item carries nothing")

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for csv_field_splitter_unit: drives random and hand-built
// lines, predicts every result item and checks it field by field.
// Depends on csfs_pkg and the csv_field_splitter_unit RTL.
`timescale 1ns / 1ps

module tb;
   import csfs_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASE_ITEMS = 175;

   // Tracks separator registers and parse state, and holds predicted fields
   class csv_field_tracker;
      logic [7:0]       sep_char [SEP_NUM];
      logic [2:0]       sep_count;
      mode_type         mode;
      logic [CNT_W-1:0] field_cnt;
      logic             over;
      result_type       pending_fields [$];
      int               errors;

      function new();
         for (int i = 0; i < SEP_NUM; i++) sep_char[i] = SEP_RESET;
         sep_count = COUNT_RESET;
         mode      = MODE_START;
         field_cnt = '0;
         over      = 1'b0;
         errors    = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         if (idx == REG_COUNT) sep_count = value[2:0];
         else if (idx <= REG_SEP3) sep_char[idx] = value[7:0];
      endfunction

      // Zero acts as one, anything past four as four
      function int active_count();
         if (sep_count < 1) return 1;
         if (sep_count > SEP_NUM) return SEP_NUM;
         return int'(sep_count);
      endfunction

      function bit is_sep(logic [7:0] b);
         for (int i = 0; i < active_count(); i++)
            if (sep_char[i] == b) return 1'b1;
         return 1'b0;
      endfunction

      function logic [7:0] any_sep();
         return sep_char[$urandom_range(0, active_count() - 1)];
      endfunction

      function void flag(string msg);
         errors++;
         $display("%s", msg);
      endfunction

      // Advance the parse state by one accepted byte
      function void take_byte(logic [7:0] b, logic eol);
         result_type r;
         r = '0;
         case (mode)
            MODE_PLAIN, MODE_TAIL: begin
               if (is_sep(b)) r.field_end = 1'b1;
               else r.data_valid = 1'b1;
            end
            MODE_QUOTED: begin
               if (b == QUOTE_BYTE) mode = MODE_QUOTE_SEEN;
               else r.data_valid = 1'b1;
            end
            MODE_QUOTE_SEEN: begin
               if (b == QUOTE_BYTE) begin
                  r.data_valid = 1'b1;
                  mode = MODE_QUOTED;
               end else if (is_sep(b)) begin
                  r.field_end = 1'b1;
               end else begin
                  r.data_valid = 1'b1;
                  mode = MODE_TAIL;
               end
            end
            default: begin
               if (b == QUOTE_BYTE) begin
                  mode = MODE_QUOTED;
               end else if (is_sep(b)) begin
                  r.field_end = 1'b1;
               end else begin
                  r.data_valid = 1'b1;
                  mode = MODE_PLAIN;
               end
            end
         endcase
         if (eol) r.field_end = 1'b1;
         if (!(r.data_valid || r.field_end)) return;

         r.has_result     = 1'b1;
         r.data_byte      = r.data_valid ? b : 8'h00;
         r.line_end       = eol;
         r.field_index    = field_cnt[IDX_W-1:0];
         r.field_overflow = over;
         pending_fields.push_back(r);

         if (r.field_end) begin
            mode = MODE_START;
            if (int'(field_cnt) + 1 >= MAX_FIELDS) over = 1'b1;
            else field_cnt++;
         end
         if (eol) begin
            mode      = MODE_START;
            field_cnt = '0;
            over      = 1'b0;
         end
      endfunction

      function void check(string name, int unsigned want, int unsigned got);
         if (want != got)
            flag($sformatf("%0t: %s mismatch, expected %0h, actual %0h",
                           $time, name, want, got));
      endfunction

      // Compare a delivered item with the oldest prediction
      function void match_field(result_type got);
         result_type want;
         if (pending_fields.size() == 0) begin
            flag($sformatf("%0t: result item with none expected, expected none, actual %h",
                           $time, got));
            return;
         end
         want = pending_fields[0];
         pending_fields.delete(0);
         check("data_byte", want.data_byte, got.data_byte);
         check("data_valid", want.data_valid, got.data_valid);
         check("field_end", want.field_end, got.field_end);
         check("line_end", want.line_end, got.line_end);
         check("field_index", want.field_index, got.field_index);
         check("field_overflow", want.field_overflow, got.field_overflow);
      endfunction

      function int pending();
         return pending_fields.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_byte;
   logic        req_end_of_line;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_data_byte;
   logic        rsp_data_valid;
   logic        rsp_field_end;
   logic        rsp_line_end;
   logic [4:0]  rsp_field_index;
   logic        rsp_field_overflow;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   csv_field_tracker tracker = new();
   logic [7:0]       line_q [$];
   int               items_sent;
   int               req_steady;
   int               rsp_steady;
   int               idle_cycles;

   csv_field_splitter_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Draw a random pause length, or none during a steady stretch
   function automatic int draw_pause(inout int steady);
      if (steady > 0) begin
         steady--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) steady = $urandom_range(10, 60);
      return $urandom_range(0, 19);
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0: return QUOTE_BYTE;
         1: return tracker.sep_char[$urandom_range(0, SEP_NUM - 1)];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == QUOTE_BYTE || tracker.is_sep(c));
      return c;
   endfunction

   // Present one byte, hold it until taken
   task automatic send_byte(logic [7:0] b, logic eol);
      int gap;
      gap = draw_pause(req_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_char_byte   <= b;
      req_end_of_line <= eol;
      do @(posedge clock); while (req_stall);
      tracker.take_byte(b, eol);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
   endtask

   task automatic send_text(string s);
      line_q.delete();
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
      send_line();
   endtask

   // Mostly well-formed fields with random content, some noise fields
   task automatic build_line();
      int         nf;
      int         len;
      logic [7:0] c;
      line_q.delete();
      nf = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
      for (int f = 0; f < nf; f++) begin
         if (f > 0) line_q.push_back(tracker.any_sep());
         case ($urandom_range(0, 9))
            0: ;
            1, 2: begin
               len = $urandom_range(1, 6);
               repeat (len) line_q.push_back(noise_byte());
            end
            3, 4, 5: begin
               line_q.push_back(QUOTE_BYTE);
               len = $urandom_range(0, 5);
               repeat (len) begin
                  c = noise_byte();
                  line_q.push_back(c);
                  if (c == QUOTE_BYTE) line_q.push_back(c);
               end
               // leave the last field open now and then
               if (f < nf - 1 || $urandom_range(0, 5) != 0) begin
                  line_q.push_back(QUOTE_BYTE);
                  if ($urandom_range(0, 2) == 0) begin
                     len = $urandom_range(1, 2);
                     repeat (len) line_q.push_back(plain_byte());
                  end
               end
            end
            default: begin
               len = $urandom_range(1, 5);
               repeat (len) line_q.push_back(plain_byte());
            end
         endcase
      end
      if ($urandom_range(0, 4) == 0) line_q.push_back(tracker.any_sep());
      if (line_q.size() == 0) line_q.push_back(noise_byte());
   endtask

   // Drop valid and hold off until every predicted item has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register, then read it back
   task automatic csr_access(logic [2:0] idx, logic [7:0] value);
      logic [31:0] mask;
      logic [31:0] word;
      mask = (idx == REG_COUNT) ? 32'h7 : 32'hff;
      word = ($urandom & ~mask) | ({24'b0, value} & mask);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_register(idx, word);
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (word & mask))
         tracker.flag($sformatf("%0t: register %0d readback, expected %h, actual %h",
                                $time, idx, word & mask, csr_prdata));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(int p);
      logic [7:0] s0, s1, s2, s3, n;
      s0 = 8'($urandom_range(0, 255));
      s1 = 8'($urandom_range(0, 255));
      s2 = 8'($urandom_range(0, 255));
      s3 = 8'($urandom_range(0, 255));
      n  = 8'd1;
      case (p)
         1: begin s0 = 8'h3b; s1 = 8'h09; s2 = 8'h7c; s3 = 8'h2c; n = 8'd4; end
         2: begin s0 = 8'h00; s1 = 8'hff; n = 8'd2; end
         3: begin s0 = QUOTE_BYTE; s1 = 8'h2c; n = 8'd2; end
         4: begin s0 = 8'h20; n = 8'd0; end
         5: n = 8'd7;
         6: n = 8'd5;
         7: n = 8'd3;
         default: begin
            s0 = SEP_RESET; s1 = SEP_RESET; s2 = SEP_RESET; s3 = SEP_RESET;
            n = COUNT_RESET;
         end
      endcase
      csr_access(REG_SEP0, s0);
      csr_access(REG_SEP1, s1);
      csr_access(REG_SEP2, s2);
      csr_access(REG_SEP3, s3);
      csr_access(REG_COUNT, n);
   endtask

   // Result side: random stall per item, check on every handshake
   initial begin
      result_type got;
      int         gap;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_pause(rsp_steady);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.has_result     = 1'b1;
         got.data_byte      = rsp_data_byte;
         got.data_valid     = rsp_data_valid;
         got.field_end      = rsp_field_end;
         got.line_end       = rsp_line_end;
         got.field_index    = rsp_field_index;
         got.field_overflow = rsp_field_overflow;
         tracker.match_field(got);
         @(negedge clock);
      end
   end

   // End the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d items outstanding", $time, tracker.pending());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int phase_start;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_char_byte   = 8'h00;
      req_end_of_line = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      items_sent      = 0;
      req_steady      = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Quoted field with doubled quote, tail after close, trailing separator
      send_text("\"a\"\"b\"c,");
      // Leading empty field, zero byte, all-ones byte
      line_q = '{8'h2c, 8'h00, 8'hff};
      send_line();
      // Close then separator, then a quote left open at line end
      send_text("\"x\",\"");
      // Empty quoted field closed on the last byte
      send_text("\"\"");
      // Single-byte line, quote inside a plain field
      send_text("q");
      send_text("ab\"c,d");

      for (int p = 1; p <= 8; p++) begin
         wait_idle();
         apply_setting(p);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            build_line();
            send_line();
            if ($urandom_range(0, 24) == 0) wait_idle();
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.flag($sformatf("%0t: %0d predicted items never arrived",
                                $time, tracker.pending()));
      if (tracker.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: csv_field_splitter_unit.f
+incdir+src
src/csfs_pkg.sv
src/csfs_csr.sv
src/csfs_parse.sv
src/csv_field_splitter_unit.sv
tb/sv/tb.sv
